[src/stq_pkg.sv]
// Shared types and constants for the sorted timeout queue.
package stq_pkg;
	localparam int TIME_BITS = 63;
	localparam int ID_BITS = 8;
	localparam int MAX_RESULTS = 16;
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_EXPIRE = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_READ  = 7'b0000010,
		ST_CMP   = 7'b0000100,
		ST_PLACE = 7'b0001000,
		ST_HEAD  = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;
endpackage

[src/sorted_timeout_queue.sv]
// Sorted timeout queue: a deadline-ordered list of waiters held in one RAM.
//
// Entries sit in one synchronous RAM, sorted by deadline, with the head at a
// rotating base address. Every entry visited takes a read state and a compare
// state, since the RAM read is registered. An insert walks down from the tail,
// moving each entry with a later or equal deadline up one place, then writes
// the new entry and reads back the head; a full queue drops the insert and
// only reads back the head. An expire pops due entries from the head, at most
// MAX_RESULTS per transaction. Each result is held while the output stalls.
// One transaction is worked at a time; the input stalls until its last result
// has been taken.
module sorted_timeout_queue
	import stq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int WAITER_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [TIME_BITS-1:0] time_value,
	input  logic [ID_BITS-1:0]   waiter_id,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 woken_valid,
	output logic [ID_BITS-1:0]   woken_waiter,
	output logic [TIME_BITS-1:0] next_deadline,
	output logic                 insert_dropped,
	output logic                 last
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = TIME_BITS + WAITER_BITS;
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
	localparam logic [NW-1:0] WOKEN_MAX = NW'(MAX_RESULTS);

	logic [EW-1:0] mem [QUEUE_DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [EW-1:0] wr_data;

	state_t        state_q;
	logic [AW-1:0] base_q;
	logic [CW-1:0] count_q, idx_q;
	logic          mode_q;
	logic [TIME_BITS-1:0] t_q;
	logic [WAITER_BITS-1:0] w_q;
	logic [WAITER_BITS-1:0] pend_q;
	logic          have_q;
	logic [NW-1:0] woken_q;

	logic [TIME_BITS-1:0] rd_dl;
	logic [WAITER_BITS-1:0] rd_w;
	logic          later;
	logic          due;
	logic [TIME_BITS-1:0] head_dl;

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [CW-1:0] o);
		logic [CW:0] s;
		s = (CW+1)'(b) + (CW+1)'(o);
		if (s >= (CW+1)'(QUEUE_DEPTH))
			s = s - (CW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign rd_dl = rd_q[EW-1:WAITER_BITS];
	assign rd_w = rd_q[WAITER_BITS-1:0];
	assign later = (rd_dl >= t_q);
	assign due = (count_q != '0) && (woken_q != WOKEN_MAX) && (rd_dl <= t_q);
	assign head_dl = (count_q != '0) ? rd_dl : '0;

	assign in_stall = (state_q != ST_IDLE);
	assign rd_addr = wrap(base_q, idx_q);

	// CMP on insert: a later or equal entry moves up one place, else the new one lands above it
	always_comb begin
		wr_en = 1'b0;
		wr_addr = wrap(base_q, CW'(idx_q + 1'b1));
		wr_data = {t_q, w_q};
		if (state_q == ST_PLACE) begin
			wr_en = 1'b1;
			wr_addr = base_q;
		end else if (state_q == ST_CMP && mode_q == MODE_INSERT) begin
			wr_en = 1'b1;
			if (later)
				wr_data = rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			mode_q <= MODE_INSERT;
			t_q <= '0;
			w_q <= '0;
			pend_q <= '0;
			have_q <= 1'b0;
			woken_q <= '0;
			out_valid <= 1'b0;
			woken_valid <= 1'b0;
			woken_waiter <= '0;
			next_deadline <= '0;
			insert_dropped <= 1'b0;
			last <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						t_q <= time_value;
						w_q <= WAITER_BITS'(waiter_id);
						have_q <= 1'b0;
						woken_q <= '0;
						insert_dropped <= 1'b0;
						idx_q <= '0;
						if (mode == MODE_EXPIRE) begin
							state_q <= ST_READ;
						end else if (count_q == FULL) begin
							insert_dropped <= 1'b1;
							state_q <= ST_HEAD;
						end else if (count_q == '0) begin
							state_q <= ST_PLACE;
						end else begin
							idx_q <= count_q - 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_CMP;
				ST_CMP: begin
					if (mode_q == MODE_INSERT) begin
						if (!later) begin
							count_q <= count_q + 1'b1;
							idx_q <= '0;
							state_q <= ST_HEAD;
						end else if (idx_q == '0) begin
							state_q <= ST_PLACE;
						end else begin
							idx_q <= idx_q - 1'b1;
							state_q <= ST_READ;
						end
					end else if (due) begin
						// pop the head; the held waiter goes out once more are known due
						pend_q <= rd_w;
						have_q <= 1'b1;
						base_q <= wrap(base_q, CW'(1));
						count_q <= count_q - 1'b1;
						woken_q <= woken_q + 1'b1;
						if (have_q) begin
							woken_valid <= 1'b1;
							woken_waiter <= ID_BITS'(pend_q);
							next_deadline <= '0;
							last <= 1'b0;
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_READ;
						end
					end else begin
						woken_valid <= have_q;
						woken_waiter <= have_q ? ID_BITS'(pend_q) : '0;
						next_deadline <= head_dl;
						last <= 1'b1;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + 1'b1;
					idx_q <= '0;
					state_q <= ST_HEAD;
				end
				ST_HEAD: state_q <= ST_FIN;
				ST_FIN: begin
					woken_valid <= 1'b0;
					woken_waiter <= '0;
					next_deadline <= head_dl;
					last <= 1'b1;
					out_valid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= last ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[tb/sorted_timeout_queue_checker.sv]
// Checker for the sorted timeout queue: predicts results and compares them.
`timescale 1ns / 1ps
module sorted_timeout_queue_checker
	import stq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 mode,
	input  logic [TIME_BITS-1:0] time_value,
	input  logic [ID_BITS-1:0]   waiter_id,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 woken_valid,
	input  logic [ID_BITS-1:0]   woken_waiter,
	input  logic [TIME_BITS-1:0] next_deadline,
	input  logic                 insert_dropped,
	input  logic                 last,
	output int                   fail_count,
	output int                   pending
);
	localparam int DEPTH = 16;
	localparam int MAX_WOKEN = 16;

	typedef struct packed {
		logic                 woken_valid;
		logic [ID_BITS-1:0]   woken_waiter;
		logic [TIME_BITS-1:0] next_deadline;
		logic                 insert_dropped;
		logic                 last;
	} wake_rec_t;

	logic [TIME_BITS-1:0] q_deadline[DEPTH];
	logic [ID_BITS-1:0]   q_waiter[DEPTH];
	int                   q_count;
	wake_rec_t            expected_wakes[$];

	function automatic logic [TIME_BITS-1:0] head_time();
		return q_count == 0 ? '0 : q_deadline[0];
	endfunction

	task automatic report(input string what, input logic [TIME_BITS-1:0] got,
			input logic [TIME_BITS-1:0] want);
		$display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic predict_timer(input logic m, input logic [TIME_BITS-1:0] t,
			input logic [ID_BITS-1:0] w);
		int pos;
		int n;
		wake_rec_t r;
		r = '0;
		r.last = 1'b1;
		if (m == MODE_INSERT) begin
			if (q_count >= DEPTH) begin
				r.insert_dropped = 1'b1;
			end else begin
				pos = 0;
				while (pos < q_count && q_deadline[pos] < t) pos++;
				for (int i = q_count; i > pos; i--) begin
					q_deadline[i] = q_deadline[i-1];
					q_waiter[i] = q_waiter[i-1];
				end
				q_deadline[pos] = t;
				q_waiter[pos] = w;
				q_count++;
			end
			r.next_deadline = head_time();
			expected_wakes.push_back(r);
		end else begin
			n = 0;
			while (n < q_count && n < MAX_WOKEN && q_deadline[n] <= t) n++;
			for (int i = 0; i < n; i++) begin
				r = '0;
				r.woken_valid = 1'b1;
				r.woken_waiter = q_waiter[i];
				expected_wakes.push_back(r);
			end
			for (int i = n; i < q_count; i++) begin
				q_deadline[i-n] = q_deadline[i];
				q_waiter[i-n] = q_waiter[i];
			end
			q_count -= n;
			if (n == 0) begin
				r = '0;
				expected_wakes.push_back(r);
			end
			r = expected_wakes.pop_back();
			r.next_deadline = head_time();
			r.last = 1'b1;
			expected_wakes.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		wake_rec_t e;
		if (!arst_n) begin
			q_count = 0;
			fail_count = 0;
			expected_wakes.delete();
			pending = 0;
		end else begin
			if (in_valid && !in_stall) predict_timer(mode, time_value, waiter_id);
			if (out_valid && !out_stall) begin
				if (expected_wakes.size() == 0) begin
					report("unexpected transaction", '0, '0);
				end else begin
					e = expected_wakes.pop_front();
					if (woken_valid !== e.woken_valid)
						report("woken_valid", TIME_BITS'(woken_valid),
							TIME_BITS'(e.woken_valid));
					if (woken_waiter !== e.woken_waiter)
						report("woken_waiter", TIME_BITS'(woken_waiter),
							TIME_BITS'(e.woken_waiter));
					if (next_deadline !== e.next_deadline)
						report("next_deadline", next_deadline, e.next_deadline);
					if (insert_dropped !== e.insert_dropped)
						report("insert_dropped", TIME_BITS'(insert_dropped),
							TIME_BITS'(e.insert_dropped));
					if (last !== e.last)
						report("last", TIME_BITS'(last), TIME_BITS'(e.last));
				end
			end
			pending = expected_wakes.size();
		end
	end
endmodule

[tb/sorted_timeout_queue_tb.sv]
// Testbench top for the sorted timeout queue: stimulus and verdict.
`timescale 1ns / 1ps
module sorted_timeout_queue_tb
	import stq_pkg::*;
();
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 mode;
	logic [TIME_BITS-1:0] time_value;
	logic [ID_BITS-1:0]   waiter_id;
	logic                 out_valid;
	logic                 out_stall;
	logic                 woken_valid;
	logic [ID_BITS-1:0]   woken_waiter;
	logic [TIME_BITS-1:0] next_deadline;
	logic                 insert_dropped;
	logic                 last;
	int                   fail_count;
	int                   pending;
	int                   cycles;
	logic                 hold_off;
	logic                 sent_all;

	sorted_timeout_queue dut (.*);
	sorted_timeout_queue_checker chk (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sorted_timeout_queue: mismatch");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		in_valid = 1'b0;
		mode = MODE_INSERT;
		time_value = '0;
		waiter_id = '0;
		out_stall = 1'b1;
		hold_off = 1'b0;
		sent_all = 1'b0;
	end

	// receiver: random stalls, one long hold-off while the queue fills
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		out_stall <= 1'b0;
		while (1) begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
				out_stall <= 1'b0;
				wait (!hold_off);
			end else if (out_valid && !out_stall) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
				if (gap != 0) begin
					out_stall <= 1'b1;
					repeat (gap - 1) @(posedge clk);
					@(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send_timer(input logic m, input logic [TIME_BITS-1:0] t,
			input logic [ID_BITS-1:0] w, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		time_value <= t;
		waiter_id <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [TIME_BITS-1:0] rand_time(input logic [TIME_BITS-1:0] base);
		case ($urandom_range(0, 5))
			0: return TIME_BITS'({$urandom, $urandom});
			1: return TIME_MAX - TIME_BITS'($urandom_range(0, 3));
			2: return TIME_BITS'($urandom_range(0, 3));
			default: return base + TIME_BITS'($urandom_range(0, 40));
		endcase
	endfunction

	function automatic int rand_gap();
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
	endfunction

	initial begin
		logic [TIME_BITS-1:0] now;
		@(posedge arst_n);
		@(posedge clk);
		// directed: empty expire, extremes, equal deadlines, overflow, bulk expire
		send_timer(MODE_EXPIRE, '0, 8'hff, 0);
		send_timer(MODE_INSERT, TIME_MAX, 8'hff, 0);
		send_timer(MODE_INSERT, '0, 8'h00, 1);
		send_timer(MODE_INSERT, 63'd5, 8'h55, 0);
		send_timer(MODE_INSERT, 63'd5, 8'haa, 0);
		send_timer(MODE_EXPIRE, 63'd4, 8'h00, 0);
		send_timer(MODE_EXPIRE, 63'd5, 8'h00, 2);
		for (int i = 0; i < 16; i++)
			send_timer(MODE_INSERT, 63'd100 - TIME_BITS'(i), i[7:0], 0);
		send_timer(MODE_EXPIRE, TIME_MAX, 8'h00, 0);
		send_timer(MODE_EXPIRE, TIME_MAX, 8'h00, 0);
		// long receiver hold-off while inserts pile up
		hold_off <= 1'b1;
		for (int i = 0; i < 20; i++)
			send_timer(MODE_INSERT, TIME_BITS'($urandom_range(0, 50)), ID_BITS'($urandom), 0);
		hold_off <= 1'b0;
		send_timer(MODE_EXPIRE, TIME_MAX, 8'h00, 0);
		// random: timer-like traffic with a moving current time
		now = 63'd1000;
		for (int i = 0; i < 260; i++) begin
			if ($urandom_range(0, 2) != 0) begin
				send_timer(MODE_INSERT, rand_time(now), ID_BITS'($urandom), rand_gap());
			end else begin
				now = now + TIME_BITS'($urandom_range(0, 30));
				send_timer(MODE_EXPIRE, ($urandom_range(0, 9) == 0) ? rand_time(now) : now,
					ID_BITS'($urandom), rand_gap());
			end
		end
		send_timer(MODE_EXPIRE, TIME_MAX, 8'h00, 0);
		send_timer(MODE_EXPIRE, TIME_MAX, 8'h00, 0);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("sorted_timeout_queue: match");
		else
			$display("sorted_timeout_queue: mismatch");
		$finish;
	end
endmodule

[files.f]
src/stq_pkg.sv
src/sorted_timeout_queue.sv
tb/sorted_timeout_queue_checker.sv
tb/sorted_timeout_queue_tb.sv
